@@ src/nmqt_pkg.sv @@
// nmqt_pkg: shared widths, defaults and codes for the named message queue table
// no dependencies; imported by the channel interfaces, the table module and the testbench

package nmqt_pkg;

   // request field widths
   localparam int OPCODE_W = 3;
   localparam int NAME_W   = 64;
   localparam int ID_W     = 3;
   localparam int LEN_W    = 5;
   localparam int DREQ_W   = 3;
   localparam int MSG_W    = 64;

   // response field widths
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 2;

   // default sizing of the table
   localparam int NUM_QUEUES_DEF    = 4;
   localparam int MAX_MSG_BYTES_DEF = 16;
   localparam int MAX_DEPTH_DEF     = 4;
   localparam int NAME_BYTES_DEF    = 8;

   // request operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_MAKE   = 3'd0,
      OP_OPEN   = 3'd1,
      OP_DELETE = 3'd2,
      OP_READ   = 3'd3,
      OP_WRITE  = 3'd4
   } opcode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_REFUSED    = 2'd1,
      ST_EMPTY_WAIT = 2'd2,
      ST_FULL_WAIT  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_RDWAIT,
      S_DONE
   } state_type;

endpackage

@@ src/nmqt_req_if.sv @@
// nmqt_req_if: request channel (valid/ready plus request fields)
// depends on nmqt_pkg for field widths

interface nmqt_req_if
   import nmqt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [NAME_W-1:0]   queue_name;
   logic [ID_W-1:0]     queue_id;
   logic [LEN_W-1:0]    msg_length;
   logic [DREQ_W-1:0]   depth_request;
   logic                no_wait;
   logic [MSG_W-1:0]    msg_low;
   logic [MSG_W-1:0]    msg_high;

   modport source (
      output valid, opcode, queue_name, queue_id, msg_length, depth_request,
             no_wait, msg_low, msg_high,
      input  ready
   );

   modport sink (
      input  valid, opcode, queue_name, queue_id, msg_length, depth_request,
             no_wait, msg_low, msg_high,
      output ready
   );
endinterface

@@ src/nmqt_rsp_if.sv @@
// nmqt_rsp_if: response channel (valid/ready plus response fields)
// depends on nmqt_pkg for field widths

interface nmqt_rsp_if
   import nmqt_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FOUND_W-1:0]  found_id;
   logic [MSG_W-1:0]    data_low;
   logic [MSG_W-1:0]    data_high;

   modport source (
      output valid, status, found_id, data_low, data_high,
      input  ready
   );

   modport sink (
      input  valid, status, found_id, data_low, data_high,
      output ready
   );
endinterface

@@ src/named_message_queue_table.sv @@
// named_message_queue_table: table of named message rings with a slot scanner
// depends on nmqt_pkg, nmqt_req_if, nmqt_rsp_if and nmqt_ram
//
//   channel   | direction | contents
//   ----------+-----------+-------------------------------------------------
//   req_chan  | in        | opcode, queue name, id, length, depth, no_wait, msg
//   rsp_chan  | out       | status, found id, data low/high
//
// make/open/delete: accept, a scan of all NUM_QUEUES slots (one name compare
//   per cycle through the shared comparator), execute, load the response
// read with a message queued: accept, execute, wait for the message ram's registered read, load
// other reads, writes and refused requests: accept, execute, load
// synchronous reset clears the in-use marks, the sequencer and the response valid; no clearing pass
// a new request is taken while an earlier response still waits on rsp_chan;
//   a finished request holds in the load state until the response register frees

module named_message_queue_table
   import nmqt_pkg::*;
#(
   parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
   parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF,
   parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
   parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nmqt_req_if.sink    req_chan,
   nmqt_rsp_if.source  rsp_chan
);

   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DW        = $clog2(MAX_DEPTH + 1);
   localparam int LW        = $clog2(MAX_MSG_BYTES + 1);
   localparam int RAM_DEPTH = NUM_QUEUES * MAX_DEPTH;
   localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam int ENT_W     = 2 * MSG_W;
   localparam int ENT_BYTES = ENT_W / 8;
   localparam logic [NAME_W-1:0] NAME_KEY = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
      ((NAME_W'(1) << (8 * NAME_BYTES)) - NAME_W'(1));

   // latched request
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [NAME_W-1:0]   queue_name;
      logic [ID_W-1:0]     queue_id;
      logic [LEN_W-1:0]    msg_length;
      logic [DREQ_W-1:0]   depth_request;
      logic                no_wait;
      logic [MSG_W-1:0]    msg_low;
      logic [MSG_W-1:0]    msg_high;
   } req_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [QW-1:0]      scan_idx_ff, scan_idx_in;
   logic               match_hit_ff, match_hit_in;
   logic [QW-1:0]      match_idx_ff, match_idx_in;
   logic               free_hit_ff, free_hit_in;
   logic [QW-1:0]      free_idx_ff, free_idx_in;

   logic               in_use_ff [NUM_QUEUES];
   logic               in_use_in [NUM_QUEUES];
   logic [NAME_W-1:0]  name_ff   [NUM_QUEUES];
   logic [NAME_W-1:0]  name_in   [NUM_QUEUES];
   logic [LW-1:0]      len_ff    [NUM_QUEUES];
   logic [LW-1:0]      len_in    [NUM_QUEUES];
   logic [DW-1:0]      depth_ff  [NUM_QUEUES];
   logic [DW-1:0]      depth_in  [NUM_QUEUES];
   logic [DW-1:0]      count_ff  [NUM_QUEUES];
   logic [DW-1:0]      count_in  [NUM_QUEUES];
   logic [PW-1:0]      wptr_ff   [NUM_QUEUES];
   logic [PW-1:0]      wptr_in   [NUM_QUEUES];
   logic [PW-1:0]      rptr_ff   [NUM_QUEUES];
   logic [PW-1:0]      rptr_in   [NUM_QUEUES];

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FOUND_W-1:0]  res_found_ff, res_found_in;
   logic [ENT_W-1:0]    res_data_ff, res_data_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [ENT_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [ENT_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [ENT_W-1:0]    ram_rd_data;

   logic                req_fire;
   logic                scan_match;
   logic [QW-1:0]       id_idx;
   logic                id_ok;
   logic [ENT_W-1:0]    len_mask;

   // byte mask over a full message entry for a message of len bytes
   function automatic logic [ENT_W-1:0] byte_mask(input logic [LW-1:0] len);
      logic [ENT_W-1:0] m;
      m = '0;
      for (int b = 0; b < ENT_BYTES; b++) begin
         if (b < int'(len)) begin
            m[8*b +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   // advance a ring pointer, wrapping at the queue's depth
   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] ptr,
                                               input logic [DW-1:0] depth);
      logic [DW:0] nxt;
      nxt = (DW+1)'(ptr) + (DW+1)'(1);
      return (nxt >= (DW+1)'(depth)) ? '0 : PW'(nxt);
   endfunction

   // ring entry address of a slot and pointer
   function automatic logic [AW-1:0] entry_addr(input logic [QW-1:0] slot,
                                                input logic [PW-1:0] ptr);
      return AW'(int'(slot) * MAX_DEPTH + int'(ptr));
   endfunction

   // message ring storage, both halves of a message in one entry
   nmqt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (RAM_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // channel handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.found_id  = rsp_found_ff;
   assign rsp_chan.data_low  = rsp_data_ff[MSG_W-1:0];
   assign rsp_chan.data_high = rsp_data_ff[ENT_W-1:MSG_W];

   // shared name comparator on the slot under scan
   assign scan_match = in_use_ff[scan_idx_ff] &&
                       (((name_ff[scan_idx_ff] ^ req_ff.queue_name) & NAME_KEY) == '0);

   // slot addressed by read and write
   assign id_idx   = QW'(req_ff.queue_id);
   assign id_ok    = (int'(req_ff.queue_id) < NUM_QUEUES) && in_use_ff[id_idx];
   assign len_mask = byte_mask(len_ff[id_idx]);

   // sequencer: next state, table updates and ram control
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_idx_in   = scan_idx_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      in_use_in     = in_use_ff;
      name_in       = name_ff;
      len_in        = len_ff;
      depth_in      = depth_ff;
      count_in      = count_ff;
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = entry_addr(id_idx, wptr_ff[id_idx]);
      ram_wr_data   = {req_ff.msg_high, req_ff.msg_low} & len_mask;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = entry_addr(id_idx, rptr_ff[id_idx]);

      // response register drains on a taken response
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in.opcode        = req_chan.opcode;
               req_in.queue_name    = req_chan.queue_name;
               req_in.queue_id      = req_chan.queue_id;
               req_in.msg_length    = req_chan.msg_length;
               req_in.depth_request = req_chan.depth_request;
               req_in.no_wait       = req_chan.no_wait;
               req_in.msg_low       = req_chan.msg_low;
               req_in.msg_high      = req_chan.msg_high;
               scan_idx_in          = '0;
               match_hit_in         = 1'b0;
               match_idx_in         = '0;
               free_hit_in          = 1'b0;
               free_idx_in          = '0;
               if (req_chan.opcode == OP_MAKE || req_chan.opcode == OP_OPEN ||
                   req_chan.opcode == OP_DELETE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         // one slot per cycle: lowest match and lowest free slot
         S_SCAN: begin
            if (!match_hit_ff && scan_match) begin
               match_hit_in = 1'b1;
               match_idx_in = scan_idx_ff;
            end
            if (!free_hit_ff && !in_use_ff[scan_idx_ff]) begin
               free_hit_in = 1'b1;
               free_idx_in = scan_idx_ff;
            end
            if (scan_idx_ff == QW'(NUM_QUEUES - 1)) begin
               state_in = S_EXEC;
            end else begin
               scan_idx_in = scan_idx_ff + QW'(1);
            end
         end

         S_EXEC: begin
            res_status_in = ST_REFUSED;
            res_found_in  = '0;
            res_data_in   = '0;
            state_in      = S_DONE;
            unique case (req_ff.opcode)
               OP_MAKE: begin
                  if (req_ff.msg_length >= LEN_W'(1) &&
                      int'(req_ff.msg_length) <= MAX_MSG_BYTES &&
                      req_ff.depth_request >= DREQ_W'(1) &&
                      int'(req_ff.depth_request) <= MAX_DEPTH) begin
                     if (match_hit_ff) begin
                        res_status_in = ST_OK;
                     end else if (free_hit_ff) begin
                        name_in[free_idx_ff]   = req_ff.queue_name;
                        len_in[free_idx_ff]    = LW'(req_ff.msg_length);
                        depth_in[free_idx_ff]  = DW'(req_ff.depth_request);
                        count_in[free_idx_ff]  = '0;
                        wptr_in[free_idx_ff]   = '0;
                        rptr_in[free_idx_ff]   = '0;
                        in_use_in[free_idx_ff] = 1'b1;
                        res_status_in          = ST_OK;
                     end
                  end
               end
               OP_OPEN: begin
                  if (match_hit_ff) begin
                     res_status_in = ST_OK;
                     res_found_in  = FOUND_W'(match_idx_ff);
                  end
               end
               OP_DELETE: begin
                  if (match_hit_ff) begin
                     in_use_in[match_idx_ff] = 1'b0;
                     res_status_in           = ST_OK;
                  end
               end
               OP_READ: begin
                  if (id_ok) begin
                     if (count_ff[id_idx] == '0) begin
                        res_status_in = req_ff.no_wait ? ST_REFUSED : ST_EMPTY_WAIT;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = S_RDWAIT;
                     end
                  end
               end
               OP_WRITE: begin
                  if (id_ok) begin
                     if (count_ff[id_idx] >= depth_ff[id_idx]) begin
                        res_status_in = req_ff.no_wait ? ST_REFUSED : ST_FULL_WAIT;
                     end else begin
                        ram_wr_en        = 1'b1;
                        wptr_in[id_idx]  = ring_next(wptr_ff[id_idx], depth_ff[id_idx]);
                        count_in[id_idx] = count_ff[id_idx] + DW'(1);
                        res_status_in    = ST_OK;
                     end
                  end
               end
               default: begin
                  res_status_in = ST_REFUSED;
               end
            endcase
         end

         // merge stored bytes with the caller's bytes beyond the length
         S_RDWAIT: begin
            res_status_in    = ST_OK;
            res_data_in      = (ram_rd_data & len_mask) |
                               ({req_ff.msg_high, req_ff.msg_low} & ~len_mask);
            rptr_in[id_idx]  = ring_next(rptr_ff[id_idx], depth_ff[id_idx]);
            count_in[id_idx] = count_ff[id_idx] - DW'(1);
            state_in         = S_DONE;
         end

         // load the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_data_in   = res_data_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            in_use_ff[q] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         in_use_ff    <= in_use_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_idx_ff   <= scan_idx_in;
      match_hit_ff  <= match_hit_in;
      match_idx_ff  <= match_idx_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      name_ff       <= name_in;
      len_ff        <= len_in;
      depth_ff      <= depth_in;
      count_ff      <= count_in;
      wptr_ff       <= wptr_in;
      rptr_ff       <= rptr_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ring occupancy and pointers stay inside the queue depth
   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_ring_chk
      a_ring_bounds: assert property (@(posedge clock) disable iff (reset)
         in_use_ff[g] |-> (count_ff[g] <= depth_ff[g]) &&
                          (DW'(wptr_ff[g]) < depth_ff[g]) &&
                          (DW'(rptr_ff[g]) < depth_ff[g]))
         else $error("ring state of a queue slot out of bounds");
   end

   // a ram read is always followed by the merge cycle
   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> state_ff == S_RDWAIT)
      else $error("ram read not followed by read wait");

   // a new response only comes from the load state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the load state");

   // an accepted request always starts work
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_SCAN || state_ff == S_EXEC))
      else $error("accepted request did not start");

endmodule

@@ src/nmqt_ram.sv @@
// nmqt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module nmqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for named_message_queue_table, a table of named message rings
// depends on nmqt_pkg, nmqt_req_if, nmqt_rsp_if and the table rtl; carries its own table predictor
`timescale 1ns / 1ps

module tb;
   import nmqt_pkg::*;

   localparam int OPCODE_MAX  = (1 << OPCODE_W) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 6;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [NAME_W-1:0]   queue_name;
      logic [ID_W-1:0]     queue_id;
      logic [LEN_W-1:0]    msg_length;
      logic [DREQ_W-1:0]   depth_request;
      logic                no_wait;
      logic [MSG_W-1:0]    msg_low;
      logic [MSG_W-1:0]    msg_high;
   } queue_request_type;

   typedef struct {
      status_type          status;
      logic [FOUND_W-1:0]  found_id;
      logic [MSG_W-1:0]    data_low;
      logic [MSG_W-1:0]    data_high;
   } queue_response_type;

   logic clock = 1'b0;
   logic reset;

   nmqt_req_if req_chan ();
   nmqt_rsp_if rsp_chan ();

   named_message_queue_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted table contents
   bit                slot_used  [NUM_QUEUES_DEF];
   logic [NAME_W-1:0] slot_label [NUM_QUEUES_DEF];
   int                slot_len   [NUM_QUEUES_DEF];
   int                slot_dep   [NUM_QUEUES_DEF];
   int                slot_fill  [NUM_QUEUES_DEF];
   int                slot_wr    [NUM_QUEUES_DEF];
   int                slot_rd    [NUM_QUEUES_DEF];
   logic [MSG_W-1:0]  ring_low   [NUM_QUEUES_DEF][MAX_DEPTH_DEF];
   logic [MSG_W-1:0]  ring_high  [NUM_QUEUES_DEF][MAX_DEPTH_DEF];

   queue_response_type pending_responses[$];
   logic [NAME_W-1:0]  name_pool[POOL_SIZE];
   int                 error_count = 0;
   int                 cycle_count = 0;
   bit                 idling_on = 1'b1;
   int                 hold_requests = 0;
   int                 hold_length = 0;

   // lowest used slot carrying the name, or -1
   function automatic int lookup_name(input logic [NAME_W-1:0] nm);
      for (int i = 0; i < NUM_QUEUES_DEF; i++)
         if (slot_used[i] && slot_label[i] == nm)
            return i;
      return -1;
   endfunction

   // byte mask over one 64-bit half of a message of len bytes
   function automatic logic [MSG_W-1:0] byte_mask(input int len, input int first);
      if (len <= first)
         return '0;
      if (len - first >= 8)
         return '1;
      return (64'd1 << (8 * (len - first))) - 64'd1;
   endfunction

   // expected response of one request; updates the predicted table
   function automatic queue_response_type predict_table_response(input queue_request_type r);
      queue_response_type rsp;
      int slot;
      int id;
      logic [MSG_W-1:0] lo_mask;
      logic [MSG_W-1:0] hi_mask;
      rsp.status    = ST_REFUSED;
      rsp.found_id  = '0;
      rsp.data_low  = '0;
      rsp.data_high = '0;
      id = int'(r.queue_id);
      unique case (r.opcode)
         OP_MAKE: begin
            if (r.msg_length >= 1 && r.msg_length <= MAX_MSG_BYTES_DEF &&
                r.depth_request >= 1 && r.depth_request <= MAX_DEPTH_DEF) begin
               if (lookup_name(r.queue_name) >= 0) begin
                  rsp.status = ST_OK;
               end else begin
                  slot = -1;
                  for (int i = NUM_QUEUES_DEF - 1; i >= 0; i--)
                     if (!slot_used[i])
                        slot = i;
                  if (slot >= 0) begin
                     slot_label[slot] = r.queue_name;
                     slot_len[slot]   = int'(r.msg_length);
                     slot_dep[slot]   = int'(r.depth_request);
                     slot_fill[slot]  = 0;
                     slot_wr[slot]    = 0;
                     slot_rd[slot]    = 0;
                     slot_used[slot]  = 1'b1;
                     rsp.status       = ST_OK;
                  end
               end
            end
         end
         OP_OPEN: begin
            slot = lookup_name(r.queue_name);
            if (slot >= 0) begin
               rsp.status   = ST_OK;
               rsp.found_id = FOUND_W'(slot);
            end
         end
         OP_DELETE: begin
            slot = lookup_name(r.queue_name);
            if (slot >= 0) begin
               slot_used[slot] = 1'b0;
               rsp.status      = ST_OK;
            end
         end
         OP_READ, OP_WRITE: begin
            if (id < NUM_QUEUES_DEF && slot_used[id]) begin
               lo_mask = byte_mask(slot_len[id], 0);
               hi_mask = byte_mask(slot_len[id], 8);
               if (r.opcode == OP_READ) begin
                  if (slot_fill[id] == 0) begin
                     rsp.status = r.no_wait ? ST_REFUSED : ST_EMPTY_WAIT;
                  end else begin
                     rsp.data_low  = (ring_low[id][slot_rd[id]] & lo_mask) |
                                     (r.msg_low & ~lo_mask);
                     rsp.data_high = (ring_high[id][slot_rd[id]] & hi_mask) |
                                     (r.msg_high & ~hi_mask);
                     slot_rd[id]   = (slot_rd[id] + 1 >= slot_dep[id]) ? 0 : slot_rd[id] + 1;
                     slot_fill[id]--;
                     rsp.status    = ST_OK;
                  end
               end else begin
                  if (slot_fill[id] >= slot_dep[id]) begin
                     rsp.status = r.no_wait ? ST_REFUSED : ST_FULL_WAIT;
                  end else begin
                     ring_low[id][slot_wr[id]]  = r.msg_low & lo_mask;
                     ring_high[id][slot_wr[id]] = r.msg_high & hi_mask;
                     slot_wr[id] = (slot_wr[id] + 1 >= slot_dep[id]) ? 0 : slot_wr[id] + 1;
                     slot_fill[id]++;
                     rsp.status  = ST_OK;
                  end
               end
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // drive one request, wait for the handshake, then maybe leave a gap
   task automatic send_request(input queue_request_type r);
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= r.opcode;
      req_chan.queue_name    <= r.queue_name;
      req_chan.queue_id      <= r.queue_id;
      req_chan.msg_length    <= r.msg_length;
      req_chan.depth_request <= r.depth_request;
      req_chan.no_wait       <= r.no_wait;
      req_chan.msg_low       <= r.msg_low;
      req_chan.msg_high      <= r.msg_high;
      do @(posedge clock); while (!req_chan.ready);
      pending_responses.push_back(predict_table_response(r));
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic issue_request(input logic [OPCODE_W-1:0] op, input logic [NAME_W-1:0] nm,
                                input int id, input int len, input int dep, input int nw,
                                input logic [MSG_W-1:0] lo, input logic [MSG_W-1:0] hi);
      queue_request_type r;
      r.opcode        = op;
      r.queue_name    = nm;
      r.queue_id      = ID_W'(id);
      r.msg_length    = LEN_W'(len);
      r.depth_request = DREQ_W'(dep);
      r.no_wait       = 1'(nw);
      r.msg_low       = lo;
      r.msg_high      = hi;
      send_request(r);
   endtask

   // mostly well-formed requests on a small name pool, some pure noise
   function automatic queue_request_type random_queue_request();
      queue_request_type r;
      int pick;
      int used_ids[$];
      r.opcode        = OPCODE_W'($urandom_range(0, OPCODE_MAX));
      r.queue_name    = {$urandom, $urandom};
      r.queue_id      = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      r.msg_length    = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
      r.depth_request = DREQ_W'($urandom_range(0, (1 << DREQ_W) - 1));
      r.no_wait       = 1'($urandom_range(0, 1));
      r.msg_low       = {$urandom, $urandom};
      r.msg_high      = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 8)
         return r;
      pick = $urandom_range(0, 99);
      if (pick < 29) begin
         if ($urandom_range(0, 9) != 0)
            r.queue_name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 12) begin
            r.opcode = OP_MAKE;
            if ($urandom_range(0, 6) != 0)
               r.msg_length = LEN_W'($urandom_range(1, MAX_MSG_BYTES_DEF));
            if ($urandom_range(0, 6) != 0)
               r.depth_request = DREQ_W'($urandom_range(1, MAX_DEPTH_DEF));
         end else begin
            r.opcode = (pick < 22) ? OP_OPEN : OP_DELETE;
         end
      end else begin
         r.opcode = (pick < 64) ? OP_READ : OP_WRITE;
         for (int i = 0; i < NUM_QUEUES_DEF; i++)
            if (slot_used[i])
               used_ids.push_back(i);
         if (used_ids.size() != 0 && $urandom_range(0, 9) != 0)
            r.queue_id = ID_W'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endtask

   // compare one response with the oldest expectation
   task automatic check_response();
      queue_response_type want;
      if (pending_responses.size() == 0) begin
         error_count++;
         $display("%0t: unexpected response expected none actual status %0d",
                  $time, rsp_chan.status);
         return;
      end
      want = pending_responses.pop_front();
      if (rsp_chan.status !== want.status)
         report_mismatch("status", 64'(want.status), 64'(rsp_chan.status));
      if (rsp_chan.found_id !== want.found_id)
         report_mismatch("found_id", 64'(want.found_id), 64'(rsp_chan.found_id));
      if (rsp_chan.data_low !== want.data_low)
         report_mismatch("data_low", want.data_low, rsp_chan.data_low);
      if (rsp_chan.data_high !== want.data_high)
         report_mismatch("data_high", want.data_high, rsp_chan.data_high);
   endtask

   // response side: check, then random stall bursts and the long hold-off
   initial begin : response_side
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            check_response();
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = hold_length;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // edge cases: bad make arguments, existing names, empty/full rings, full table
   task automatic test_directed();
      logic [NAME_W-1:0] name_a;
      logic [NAME_W-1:0] name_x;
      logic [NAME_W-1:0] name_y;
      name_a = 64'h0123_4567_89ab_cdef;
      name_x = 64'h8000_0000_0000_0001;
      name_y = 64'h7fff_ffff_ffff_fffe;
      issue_request(OPCODE_W'(OPCODE_MAX), name_a, 0, 1, 1, 0, '1, '1);
      issue_request(OP_MAKE, name_a, 0, 0, 1, 0, '0, '0);
      issue_request(OP_MAKE, name_a, 0, 17, 4, 0, '0, '0);
      issue_request(OP_MAKE, name_a, 0, 16, 5, 0, '0, '0);
      issue_request(OP_MAKE, name_a, 0, 1, 1, 0, '0, '0);
      issue_request(OP_MAKE, name_a, 0, 31, 7, 1, '1, '1);
      issue_request(OP_MAKE, name_a, 0, 4, 2, 0, '0, '0);
      issue_request(OP_OPEN, name_a, 7, 0, 0, 0, '0, '0);
      issue_request(OP_OPEN, '0, 0, 0, 0, 0, '0, '0);
      issue_request(OP_READ, '0, 0, 0, 0, 1, '0, '0);
      issue_request(OP_READ, '0, 0, 0, 0, 0, '0, '0);
      issue_request(OP_WRITE, '0, 7, 0, 0, 0, '1, '1);
      issue_request(OP_WRITE, '0, 1, 0, 0, 0, '1, '1);
      issue_request(OP_WRITE, '0, 0, 0, 0, 0, '1, '1);
      issue_request(OP_WRITE, '0, 0, 0, 0, 1, '1, '1);
      issue_request(OP_WRITE, '0, 0, 0, 0, 0, '1, '1);
      issue_request(OP_READ, '0, 0, 0, 0, 0, {16{4'h5}}, {16{4'ha}});
      issue_request(OP_MAKE, '1, 0, 16, 4, 0, '0, '0);
      issue_request(OP_MAKE, '0, 0, 8, 3, 0, '0, '0);
      issue_request(OP_MAKE, name_x, 0, 9, 2, 0, '0, '0);
      issue_request(OP_MAKE, name_y, 0, 1, 1, 0, '0, '0);
      issue_request(OP_WRITE, '0, 3, 0, 0, 0, 64'hfedc_ba98_7654_3210, 64'h0f1e_2d3c_4b5a_6978);
      issue_request(OP_READ, '0, 3, 0, 0, 1, '1, '1);
      issue_request(OP_OPEN, name_x, 0, 0, 0, 0, '0, '0);
      issue_request(OP_DELETE, name_a, 0, 0, 0, 0, '0, '0);
      issue_request(OP_DELETE, name_a, 0, 0, 0, 0, '0, '0);
      issue_request(OP_READ, '0, 0, 0, 0, 0, '0, '0);
   endtask

   // random mix, idling switched per chunk
   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0)
            idling_on = ($urandom_range(0, 4) != 0);
         send_request(random_queue_request());
      end
      idling_on = 1'b1;
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_receiver_hold(input int count);
      hold_length   <= 120;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < count; i++)
         send_request(random_queue_request());
   endtask

   // sender stops until every response is back
   task automatic test_pause_drain(input int count);
      for (int i = 0; i < count; i++)
         send_request(random_queue_request());
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0)
         @(posedge clock);
      for (int i = 0; i < count; i++)
         send_request(random_queue_request());
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_steady_stream(input int count);
      idling_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_request(random_queue_request());
   endtask

   // main sequence
   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.opcode        <= '0;
      req_chan.queue_name    <= '0;
      req_chan.queue_id      <= '0;
      req_chan.msg_length    <= '0;
      req_chan.depth_request <= '0;
      req_chan.no_wait       <= 1'b0;
      req_chan.msg_low       <= '0;
      req_chan.msg_high      <= '0;
      for (int i = 0; i < NUM_QUEUES_DEF; i++)
         slot_used[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++)
         name_pool[i] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(450);
      test_receiver_hold(30);
      test_pause_drain(20);
      test_steady_stream(150);

      // drain and settle
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
